### rtl/ntps_pkg.sv
// Package with the beat types and register indexes of the nearest three points search.
`timescale 1ns / 1ps

package ntps_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 34;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 2;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_X        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_Y        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_Z        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_LIMIT = 3'd4;

    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_ONE   = 34'd16777216;
    localparam logic              MODE_SINGLE = 1'b0;
    localparam logic [COUNT_W-1:0] SLOTS_FULL = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_point;
    } point_t;

    typedef struct packed {
        logic [INDEX_W-1:0] best_index;
        logic [INDEX_W-1:0] second_index;
        logic [INDEX_W-1:0] third_index;
        logic [COUNT_W-1:0] slots_filled;
        logic [DIST_W-1:0]  best_distance;
    } result_t;

endpackage

### rtl/nearest_three_points_search.sv
// Top level of the nearest three points search: distance pipeline and slot list.
// The beat with last_point passes the difference, square and result registers in turn.
// Throughput: one point per cycle unless stalled; slot compare and insert is combinational.
// Only a held result behind a stalled output stops the pipeline, and only when it meets
// another last point. Reset clears the registers to their reset values, the slots and counter.
`timescale 1ns / 1ps

module nearest_three_points_search #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ntps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ntps_pkg::DIST_W-1:0]         cfg_data,
    input  logic                                point_valid,
    output logic                                point_stall,
    input  ntps_pkg::point_t                    point,
    output logic                                result_valid,
    input  logic                                result_stall,
    output ntps_pkg::result_t                   result
);

    import ntps_pkg::*;

    localparam int CNT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W = 2 * COORD_W;
    localparam int SUM_W = SQ_W + 2;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_POINTS - 1);

    logic                      mode_reg;
    logic signed [COORD_W-1:0] query_x_reg;
    logic signed [COORD_W-1:0] query_y_reg;
    logic signed [COORD_W-1:0] query_z_reg;
    logic [DIST_W-1:0]         limit_reg;

    logic                      advance;
    logic                      point_accept;

    logic                      s1_valid_reg;
    logic                      s1_last_reg;
    logic signed [DIFF_W-1:0]  dx_reg;
    logic signed [DIFF_W-1:0]  dy_reg;
    logic signed [DIFF_W-1:0]  dz_reg;

    logic                      s2_valid_reg;
    logic                      s2_last_reg;
    logic [SQ_W-1:0]           sqx_reg;
    logic [SQ_W-1:0]           sqy_reg;
    logic [SQ_W-1:0]           sqz_reg;

    logic signed [2*DIFF_W-1:0] prod_x;
    logic signed [2*DIFF_W-1:0] prod_y;
    logic signed [2*DIFF_W-1:0] prod_z;

    logic [CNT_W-1:0]          counter_reg;
    logic [CNT_W-1:0]          counter_next;
    logic [DIST_W-1:0]         dist_reg [3];
    logic [DIST_W-1:0]         dist_next [3];
    logic [INDEX_W-1:0]        idx_reg [3];
    logic [INDEX_W-1:0]        idx_next [3];
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;

    logic [SUM_W-1:0]          sum;
    logic [DIST_W-1:0]         point_dist;
    logic [INDEX_W-1:0]        cur_index;
    logic [DIST_W-1:0]         thr [3];
    logic [2:0]                below;
    logic [DIST_W-1:0]         upd_dist [3];
    logic [INDEX_W-1:0]        upd_idx [3];
    logic [COUNT_W-1:0]        upd_count;

    logic                      result_valid_reg;
    logic                      result_valid_next;
    result_t                   result_reg;
    result_t                   result_next;

    // The pipeline holds only when a new result would overwrite one still waiting.
    assign advance = !(result_valid_reg && result_stall && s2_valid_reg && s2_last_reg);
    assign point_stall = !advance;
    assign point_accept = point_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_SINGLE;
            query_x_reg <= '0;
            query_y_reg <= '0;
            query_z_reg <= '0;
            limit_reg   <= DIST_ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEARCH_MODE:    mode_reg    <= cfg_data[0];
                CFG_QUERY_X:        query_x_reg <= cfg_data[COORD_W-1:0];
                CFG_QUERY_Y:        query_y_reg <= cfg_data[COORD_W-1:0];
                CFG_QUERY_Z:        query_z_reg <= cfg_data[COORD_W-1:0];
                CFG_DISTANCE_LIMIT: limit_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Stage one: axis differences. Stage two: squares.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= point_accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign prod_z = dz_reg * dz_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg <= point.last_point;
            dx_reg <= DIFF_W'(point.point_x) - DIFF_W'(query_x_reg);
            dy_reg <= DIFF_W'(point.point_y) - DIFF_W'(query_y_reg);
            dz_reg <= DIFF_W'(point.point_z) - DIFF_W'(query_z_reg);
            s2_last_reg <= s1_last_reg;
            sqx_reg <= prod_x[SQ_W-1:0];
            sqy_reg <= prod_y[SQ_W-1:0];
            sqz_reg <= prod_z[SQ_W-1:0];
        end
    end

    // Stage three: distance, slot update and result.
    always_comb
    begin
        sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
        if (SUM_W > DIST_W && (sum >> DIST_W) != '0)
        begin
            point_dist = DIST_MAX;
        end
        else
        begin
            point_dist = DIST_W'(sum);
        end
        cur_index = INDEX_W'(counter_reg);

        for (int i = 0; i < 3; i++)
        begin
            thr[i] = (COUNT_W'(i) < count_reg) ? dist_reg[i] : limit_reg;
            below[i] = point_dist < thr[i];
            upd_dist[i] = dist_reg[i];
            upd_idx[i] = idx_reg[i];
        end
        upd_count = count_reg;

        if (mode_reg == MODE_SINGLE)
        begin
            if (count_reg == '0 || point_dist < dist_reg[0])
            begin
                upd_dist[0] = point_dist;
                upd_idx[0] = cur_index;
                if (count_reg == '0)
                begin
                    upd_count = COUNT_W'(1);
                end
            end
        end
        else
        begin
            if (below[0])
            begin
                upd_dist[0] = point_dist;
                upd_idx[0] = cur_index;
                upd_dist[1] = dist_reg[0];
                upd_idx[1] = idx_reg[0];
                upd_dist[2] = dist_reg[1];
                upd_idx[2] = idx_reg[1];
            end
            else if (below[1])
            begin
                upd_dist[1] = point_dist;
                upd_idx[1] = cur_index;
                upd_dist[2] = dist_reg[1];
                upd_idx[2] = idx_reg[1];
            end
            else if (below[2])
            begin
                upd_dist[2] = point_dist;
                upd_idx[2] = cur_index;
            end
            if (below != 3'b000 && count_reg != SLOTS_FULL)
            begin
                upd_count = count_reg + COUNT_W'(1);
            end
        end

        if (mode_reg == MODE_SINGLE)
        begin
            result_next.best_index    = upd_idx[0];
            result_next.second_index  = '0;
            result_next.third_index   = '0;
            result_next.slots_filled  = COUNT_W'(1);
            result_next.best_distance = upd_dist[0];
        end
        else
        begin
            result_next.best_index    = (upd_count > COUNT_W'(0)) ? upd_idx[0] : '0;
            result_next.second_index  = (upd_count > COUNT_W'(1)) ? upd_idx[1] : '0;
            result_next.third_index   = (upd_count > COUNT_W'(2)) ? upd_idx[2] : '0;
            result_next.slots_filled  = upd_count;
            result_next.best_distance = (upd_count > COUNT_W'(0)) ? upd_dist[0] : '0;
        end

        counter_next = counter_reg;
        count_next = count_reg;
        for (int i = 0; i < 3; i++)
        begin
            dist_next[i] = dist_reg[i];
            idx_next[i] = idx_reg[i];
        end
        result_valid_next = result_valid_reg && result_stall;

        if (advance && s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                counter_next = '0;
                count_next = '0;
                for (int i = 0; i < 3; i++)
                begin
                    dist_next[i] = '0;
                    idx_next[i] = '0;
                end
                result_valid_next = 1'b1;
            end
            else
            begin
                counter_next = (counter_reg == CNT_LAST) ? '0 : counter_reg + CNT_W'(1);
                count_next = upd_count;
                for (int i = 0; i < 3; i++)
                begin
                    dist_next[i] = upd_dist[i];
                    idx_next[i] = upd_idx[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            count_reg <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                dist_reg[i] <= '0;
                idx_reg[i] <= '0;
            end
        end
        else
        begin
            counter_reg <= counter_next;
            count_reg <= count_next;
            result_valid_reg <= result_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                dist_reg[i] <= dist_next[i];
                idx_reg[i] <= idx_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg && s2_last_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule
